>>> src/mmcd_pkg.sv
// ----------------------------------------------------------------------------
// mmcd_pkg
// shared constants and types for the min/max column decimator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mmcd_pkg;

	// parameter defaults
	localparam int DEF_DOT_RADIUS_PX = 3;
	localparam int DEF_ID_BITS       = 20;
	localparam int DEF_FRAC_BITS     = 16;

	// configuration register map
	localparam int CFG_INDEX_BITS = 3;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_X_ORIGIN      = 3'd0,
		REG_X_SCALE       = 3'd1,
		REG_Y_ORIGIN      = 3'd2,
		REG_Y_SCALE       = 3'd3,
		REG_AREA_LEFT     = 3'd4,
		REG_AREA_BOTTOM   = 3'd5,
		REG_REDUCE_ENABLE = 3'd6
	} cfg_reg_t;

	// register reset values
	localparam logic [31:0] X_ORIGIN_RST    = 32'h0000_0000;
	localparam logic [31:0] SCALE_RST       = 32'h0001_0000;
	localparam logic [31:0] Y_ORIGIN_RST    = 32'h0000_0000;
	localparam logic [15:0] AREA_RST        = 16'h0000;
	localparam logic        REDUCE_RST      = 1'b1;

	// clamp on the scaled offset magnitude, far beyond the saturation range
	localparam logic [63:0] PROD_CAP = 64'd1 << 53;

	// signed 32-bit saturation bounds in a 64-bit context
	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	// kept samples per column: first, lowest, highest, last
	localparam int NUM_SLOTS = 4;

	// vertex list: old column flush plus the current item's own results
	localparam int LIST_DEPTH = 2 * NUM_SLOTS;
	localparam int LIST_IDX_BITS = $clog2(LIST_DEPTH);

	// slot of the current sample in the second half of the vertex list
	localparam logic [LIST_IDX_BITS-1:0] SAMPLE_ENTRY = LIST_IDX_BITS'(NUM_SLOTS);

	// arrival order of the kept slots for one column flush
	typedef struct packed {
		logic [NUM_SLOTS-1:0] keep; // slot emitted, not a repeat
		logic                 swap; // highest arrived before lowest
	} flush_ord_t;

endpackage

>>> src/min_max_column_decimator_top.sv
// ----------------------------------------------------------------------------
// min_max_column_decimator_top
// per-column first/min/max/last decimation of an x-ordered series into
// fixed-point pixel vertices with dot marking
// ----------------------------------------------------------------------------
// Samples enter on the in channel already sorted by x and clipped to the
// view. Each is mapped to signed fixed-point pixel coordinates (FRAC_BITS
// fraction bits, floor rounding, saturated to 32 bits). With reduce_enable
// set, the block keeps the first, lowest, highest and last sample of the
// open pixel column and emits them in arrival order, without repeats, when
// the column changes or final_sample arrives; with it clear every sample is
// emitted and drawn as a dot. run_end marks the last vertex an item causes.
// Timing: items that cause zero or one vertex run at one item per clock
// while the output is not stalled; an item causing several vertices holds
// the vertex list until the output register drains it, one vertex per clock
// when out_ready allows. An item passes the input register, multiply, scale
// and saturate, and vertex list stages, then the output register.
// Configuration writes take effect at once and are always accepted; they
// are meant for an idle block. There is no clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module min_max_column_decimator_top import mmcd_pkg::*; #(
	parameter int DOT_RADIUS_PX = DEF_DOT_RADIUS_PX,
	parameter int ID_BITS       = DEF_ID_BITS,
	parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [31:0]               cfg_data,
	// sample items
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic signed [31:0]        x_sample,
	input  logic signed [31:0]        y_sample,
	input  logic [ID_BITS-1:0]        sample_id,
	input  logic                      final_sample,
	// vertex items
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [31:0]        pixel_x,
	output logic signed [31:0]        pixel_y,
	output logic [ID_BITS-1:0]        vertex_id,
	output logic                      draw_dot,
	output logic                      run_end
);

	// integer column number width
	localparam int CW = 32 - FRAC_BITS;

	// rescale of the Q16.16 product to FRAC_BITS fraction bits
	localparam int SH_L = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
	localparam int SH_R = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;
	localparam logic [63:0] RND = (64'd1 << SH_R) - 64'd1;

	// dot radius in fixed point, and its square
	localparam int RAD_FIX = DOT_RADIUS_PX << FRAC_BITS;
	localparam int RW = $clog2(RAD_FIX);
	localparam logic [31:0] RAD_V = 32'(RAD_FIX);
	localparam logic [2*RW:0] THR = (2*RW+1)'(longint'(RAD_FIX) * longint'(RAD_FIX));

	// ------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------
	logic signed [31:0] x_origin_q, y_origin_q;
	logic [31:0]        x_scale_q, y_scale_q;
	logic [15:0]        area_left_q, area_bottom_q;
	logic               reduce_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_origin_q    <= X_ORIGIN_RST;
			x_scale_q     <= SCALE_RST;
			y_origin_q    <= Y_ORIGIN_RST;
			y_scale_q     <= SCALE_RST;
			area_left_q   <= AREA_RST;
			area_bottom_q <= AREA_RST;
			reduce_q      <= REDUCE_RST;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_X_ORIGIN:      x_origin_q    <= cfg_data;
				REG_X_SCALE:       x_scale_q     <= cfg_data;
				REG_Y_ORIGIN:      y_origin_q    <= cfg_data;
				REG_Y_SCALE:       y_scale_q     <= cfg_data;
				REG_AREA_LEFT:     area_left_q   <= cfg_data[15:0];
				REG_AREA_BOTTOM:   area_bottom_q <= cfg_data[15:0];
				REG_REDUCE_ENABLE: reduce_q      <= cfg_data[0];
				default: ; // unmapped index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline control: the three front stages move together and stall
	// only while stage 3 holds an item the vertex list cannot take yet
	// ------------------------------------------------------------------
	logic v_s1, v_s2, v_s3;
	logic adv;        // front stages move this cycle
	logic take_s3;    // stage 3 item enters the vertex list
	logic list_free;  // vertex list is empty at the end of this cycle

	assign adv      = !v_s3 || list_free;
	assign in_ready = adv;
	assign take_s3  = v_s3 && list_free;

	// stage 1: input register
	logic signed [31:0]  x_s1, y_s1;
	logic [ID_BITS-1:0]  id_s1;
	logic                fin_s1;

	// stage 2: scale products as sign and magnitude
	logic [63:0]         prod_x_s2, prod_y_s2;
	logic                neg_x_s2, neg_y_s2;
	logic signed [31:0]  y_s2;
	logic [ID_BITS-1:0]  id_s2;
	logic                fin_s2;

	// stage 3: saturated pixel coordinates
	logic signed [31:0]  px_s3, py_s3, y_s3;
	logic [ID_BITS-1:0]  id_s3;
	logic                fin_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// ------------------------------------------------------------------
	// stage 1 -> 2: offset from origin and multiply by the scale
	// ------------------------------------------------------------------
	logic signed [32:0] dx_w, dy_w;
	logic [32:0]        mag_x_w, mag_y_w;
	logic [64:0]        full_x_w, full_y_w;

	always_comb begin
		dx_w     = {x_s1[31], x_s1} - {x_origin_q[31], x_origin_q};
		dy_w     = {y_s1[31], y_s1} - {y_origin_q[31], y_origin_q};
		mag_x_w  = dx_w[32] ? 33'(-dx_w) : dx_w;
		mag_y_w  = dy_w[32] ? 33'(-dy_w) : dy_w;
		full_x_w = mag_x_w * x_scale_q;
		full_y_w = mag_y_w * y_scale_q;
	end

	// ------------------------------------------------------------------
	// stage 2 -> 3: clamp, rescale with floor rounding, add the area
	// corner and saturate to 32 bits
	// ------------------------------------------------------------------
	function automatic logic signed [63:0] scale_fix(input logic [63:0] prod,
			input logic neg);
		logic [63:0] capped;
		logic [63:0] mag;
		capped = (prod > PROD_CAP) ? PROD_CAP : prod;
		// rounding up the magnitude of a negative value gives floor
		mag = ((capped + (neg ? RND : 64'd0)) >> SH_R) << SH_L;
		scale_fix = neg ? -$signed(mag) : $signed(mag);
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
		if (v > SAT_MAX) begin
			sat32 = SAT_MAX[31:0];
		end else if (v < SAT_MIN) begin
			sat32 = SAT_MIN[31:0];
		end else begin
			sat32 = v[31:0];
		end
	endfunction

	logic signed [63:0] base_x_w, base_y_w, sum_x_w, sum_y_w;

	always_comb begin
		base_x_w = $signed(64'(area_left_q) << FRAC_BITS);
		base_y_w = $signed(64'(area_bottom_q) << FRAC_BITS);
		sum_x_w  = base_x_w + scale_fix(prod_x_s2, neg_x_s2);
		// screen y grows downward from the bottom edge
		sum_y_w  = base_y_w - scale_fix(prod_y_s2, neg_y_s2);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1      <= x_sample;
			y_s1      <= y_sample;
			id_s1     <= sample_id;
			fin_s1    <= final_sample;

			prod_x_s2 <= full_x_w[63:0];
			prod_y_s2 <= full_y_w[63:0];
			neg_x_s2  <= dx_w[32];
			neg_y_s2  <= dy_w[32];
			y_s2      <= y_s1;
			id_s2     <= id_s1;
			fin_s2    <= fin_s1;

			px_s3     <= sat32(sum_x_w);
			py_s3     <= sat32(sum_y_w);
			y_s3      <= y_s2;
			id_s3     <= id_s2;
			fin_s3    <= fin_s2;
		end
	end

	// ------------------------------------------------------------------
	// column state
	// ------------------------------------------------------------------
	logic signed [CW-1:0] open_col_q;
	logic                 col_valid_q;
	logic [ID_BITS-1:0]   stream_pos_q;
	logic signed [31:0]   lowest_q, highest_q;

	// kept slots: 0 first, 1 lowest, 2 highest, 3 last
	logic [ID_BITS-1:0]   kpos_q [NUM_SLOTS];
	logic [ID_BITS-1:0]   kid_q  [NUM_SLOTS];
	logic signed [31:0]   kpx_q  [NUM_SLOTS];
	logic signed [31:0]   kpy_q  [NUM_SLOTS];

	// arrival order of a column's kept slots; positions are compared as
	// offsets from the first sample so the counter may wrap
	function automatic flush_ord_t flush_order(input logic [ID_BITS-1:0] p0,
			input logic [ID_BITS-1:0] p1, input logic [ID_BITS-1:0] p2,
			input logic [ID_BITS-1:0] p3);
		flush_ord_t         ord;
		logic [ID_BITS-1:0] d1, d2, pa, pb, prev;
		d1 = p1 - p0;
		d2 = p2 - p0;
		ord.swap = d1 > d2;
		pa = ord.swap ? p2 : p1;
		pb = ord.swap ? p1 : p2;
		ord.keep[0] = 1'b1;
		ord.keep[1] = pa != p0;
		prev = ord.keep[1] ? pa : p0;
		ord.keep[2] = pb != prev;
		prev = ord.keep[2] ? pb : prev;
		ord.keep[3] = p3 != prev;
		flush_order = ord;
	endfunction

	logic signed [CW-1:0] col_w;
	logic                 chg_w;      // sample opens a different column
	logic                 newcol_w;   // sample starts a column
	logic                 lower_w, higher_w;
	logic [NUM_SLOTS-1:0] upd_w;      // slots that take the sample
	logic [ID_BITS-1:0]   kpos_n [NUM_SLOTS];
	logic [ID_BITS-1:0]   kid_n  [NUM_SLOTS];
	logic signed [31:0]   kpx_n  [NUM_SLOTS];
	logic signed [31:0]   kpy_n  [NUM_SLOTS];
	flush_ord_t           ord_old_w, ord_new_w;

	always_comb begin
		col_w    = px_s3[31:FRAC_BITS];
		chg_w    = col_valid_q && (col_w != open_col_q);
		newcol_w = !col_valid_q || chg_w;
		lower_w  = y_s3 < lowest_q;
		higher_w = y_s3 > highest_q;
		// ties keep the earlier sample
		upd_w    = {1'b1, newcol_w || higher_w, newcol_w || lower_w, newcol_w};
		for (int s = 0; s < NUM_SLOTS; s++) begin
			kpos_n[s] = upd_w[s] ? stream_pos_q : kpos_q[s];
			kid_n[s]  = upd_w[s] ? id_s3 : kid_q[s];
			kpx_n[s]  = upd_w[s] ? px_s3 : kpx_q[s];
			kpy_n[s]  = upd_w[s] ? py_s3 : kpy_q[s];
		end
		ord_old_w = flush_order(kpos_q[0], kpos_q[1], kpos_q[2], kpos_q[3]);
		ord_new_w = flush_order(kpos_n[0], kpos_n[1], kpos_n[2], kpos_n[3]);
	end

	// ------------------------------------------------------------------
	// vertex list: lower half holds the flush of the column being closed,
	// upper half the item's own vertices (pass-mode sample, or the flush
	// of the column that the final sample closes)
	// ------------------------------------------------------------------
	logic [LIST_DEPTH-1:0] lmask_q;
	logic                  lfin_q;    // list ends a series
	logic                  lforce_q;  // sample entry is a forced dot
	logic signed [31:0]    lpx_q [LIST_DEPTH];
	logic signed [31:0]    lpy_q [LIST_DEPTH];
	logic [ID_BITS-1:0]    lid_q [LIST_DEPTH];

	logic [LIST_DEPTH-1:0] nmask_w;
	logic signed [31:0]    npx_w [LIST_DEPTH];
	logic signed [31:0]    npy_w [LIST_DEPTH];
	logic [ID_BITS-1:0]    nid_w [LIST_DEPTH];
	logic                  flush_old_w;

	always_comb begin
		flush_old_w = reduce_q ? chg_w : col_valid_q;
		nmask_w = '0;
		if (flush_old_w) begin
			nmask_w[NUM_SLOTS-1:0] = ord_old_w.keep;
		end
		if (!reduce_q) begin
			nmask_w[SAMPLE_ENTRY] = 1'b1;
		end else if (fin_s3) begin
			nmask_w[LIST_DEPTH-1:NUM_SLOTS] = ord_new_w.keep;
		end

		// closing column, in arrival order
		npx_w[0] = kpx_q[0];
		nid_w[0] = kid_q[0];
		npy_w[0] = kpy_q[0];
		npx_w[1] = ord_old_w.swap ? kpx_q[2] : kpx_q[1];
		npy_w[1] = ord_old_w.swap ? kpy_q[2] : kpy_q[1];
		nid_w[1] = ord_old_w.swap ? kid_q[2] : kid_q[1];
		npx_w[2] = ord_old_w.swap ? kpx_q[1] : kpx_q[2];
		npy_w[2] = ord_old_w.swap ? kpy_q[1] : kpy_q[2];
		nid_w[2] = ord_old_w.swap ? kid_q[1] : kid_q[2];
		npx_w[3] = kpx_q[3];
		npy_w[3] = kpy_q[3];
		nid_w[3] = kid_q[3];

		// this item's vertices; in pass mode only the sample entry is used
		npx_w[4] = reduce_q ? kpx_n[0] : px_s3;
		npy_w[4] = reduce_q ? kpy_n[0] : py_s3;
		nid_w[4] = reduce_q ? kid_n[0] : id_s3;
		npx_w[5] = ord_new_w.swap ? kpx_n[2] : kpx_n[1];
		npy_w[5] = ord_new_w.swap ? kpy_n[2] : kpy_n[1];
		nid_w[5] = ord_new_w.swap ? kid_n[2] : kid_n[1];
		npx_w[6] = ord_new_w.swap ? kpx_n[1] : kpx_n[2];
		npy_w[6] = ord_new_w.swap ? kpy_n[1] : kpy_n[2];
		nid_w[6] = ord_new_w.swap ? kid_n[1] : kid_n[2];
		npx_w[7] = kpx_n[3];
		npy_w[7] = kpy_n[3];
		nid_w[7] = kid_n[3];
	end

	// ------------------------------------------------------------------
	// list drain into the output register, oldest entry first
	// ------------------------------------------------------------------
	logic [LIST_IDX_BITS-1:0] head_w;
	logic                     lone_w;   // head is the list's last entry
	logic                     out_load;

	always_comb begin
		head_w = '0;
		for (int i = LIST_DEPTH - 1; i >= 0; i--) begin
			if (lmask_q[i]) begin
				head_w = LIST_IDX_BITS'(i);
			end
		end
	end

	assign lone_w    = (lmask_q != '0) && ((lmask_q & (lmask_q - 1'b1)) == '0);
	assign out_load  = (lmask_q != '0) && (!out_valid || out_ready);
	assign list_free = (lmask_q == '0) || (lone_w && out_load);

	// ------------------------------------------------------------------
	// dot decision against the last dot; an axis distance at or beyond
	// the radius decides alone, otherwise the squares are summed
	// ------------------------------------------------------------------
	logic signed [31:0] ldx_q, ldy_q;
	logic               dot_placed_q;

	logic signed [31:0] hx_w, hy_w;
	logic signed [32:0] ddx_w, ddy_w;
	logic [31:0]        ax_w, ay_w;
	logic [2*RW-1:0]    x2_w, y2_w;
	logic [2*RW:0]      sq_w;
	logic               dot_w;

	always_comb begin
		hx_w  = lpx_q[head_w];
		hy_w  = lpy_q[head_w];
		ddx_w = {hx_w[31], hx_w} - {ldx_q[31], ldx_q};
		ddy_w = {hy_w[31], hy_w} - {ldy_q[31], ldy_q};
		ax_w  = ddx_w[32] ? 32'(-ddx_w) : ddx_w[31:0];
		ay_w  = ddy_w[32] ? 32'(-ddy_w) : ddy_w[31:0];
		x2_w  = ax_w[RW-1:0] * ax_w[RW-1:0];
		y2_w  = ay_w[RW-1:0] * ay_w[RW-1:0];
		sq_w  = {1'b0, x2_w} + {1'b0, y2_w};
		dot_w = (lforce_q && (head_w == SAMPLE_ENTRY)) || !dot_placed_q
			|| (ax_w >= RAD_V) || (ay_w >= RAD_V) || (sq_w >= THR);
	end

	// ------------------------------------------------------------------
	// control registers
	// ------------------------------------------------------------------
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_col_q   <= '0;
			col_valid_q  <= 1'b0;
			stream_pos_q <= '0;
			lmask_q      <= '0;
			lfin_q       <= 1'b0;
			lforce_q     <= 1'b0;
			out_valid_q  <= 1'b0;
			ldx_q        <= '0;
			ldy_q        <= '0;
			dot_placed_q <= 1'b0;
		end else begin
			if (take_s3) begin
				lmask_q  <= nmask_w;
				lfin_q   <= fin_s3;
				lforce_q <= !reduce_q;
				if (reduce_q) begin
					if (newcol_w) begin
						open_col_q <= col_w;
					end
					// a final sample flushes its column and restarts the count
					col_valid_q  <= !fin_s3;
					stream_pos_q <= fin_s3 ? '0 : stream_pos_q + 1'b1;
				end else begin
					col_valid_q <= 1'b0;
					if (fin_s3) begin
						stream_pos_q <= '0;
					end
				end
			end else if (out_load) begin
				lmask_q[head_w] <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (out_load) begin
				if (dot_w) begin
					ldx_q <= hx_w;
					ldy_q <= hy_w;
				end
				// next series starts without a placed dot
				if (lone_w && lfin_q) begin
					dot_placed_q <= 1'b0;
				end else if (dot_w) begin
					dot_placed_q <= 1'b1;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// payload registers
	// ------------------------------------------------------------------
	logic signed [31:0] pixel_x_q, pixel_y_q;
	logic [ID_BITS-1:0] vertex_id_q;
	logic               draw_dot_q, run_end_q;

	always_ff @(posedge clk) begin
		if (take_s3 && reduce_q) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				kpos_q[s] <= kpos_n[s];
				kid_q[s]  <= kid_n[s];
				kpx_q[s]  <= kpx_n[s];
				kpy_q[s]  <= kpy_n[s];
			end
			lowest_q  <= (newcol_w || lower_w) ? y_s3 : lowest_q;
			highest_q <= (newcol_w || higher_w) ? y_s3 : highest_q;
		end
		if (take_s3) begin
			lpx_q <= npx_w;
			lpy_q <= npy_w;
			lid_q <= nid_w;
		end
		if (out_load) begin
			pixel_x_q   <= hx_w;
			pixel_y_q   <= hy_w;
			vertex_id_q <= lid_q[head_w];
			draw_dot_q  <= dot_w;
			run_end_q   <= lone_w;
		end
	end

	assign out_valid = out_valid_q;
	assign pixel_x   = pixel_x_q;
	assign pixel_y   = pixel_y_q;
	assign vertex_id = vertex_id_q;
	assign draw_dot  = draw_dot_q;
	assign run_end   = run_end_q;

endmodule

>>> src/mmcd_checker.sv
// ----------------------------------------------------------------------------
// mmcd_checker
// port-level checks for the min/max column decimator
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mmcd_checker import mmcd_pkg::*; #(
	parameter int ID_BITS = DEF_ID_BITS
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_ready,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic signed [31:0]        x_sample,
	input logic signed [31:0]        y_sample,
	input logic [ID_BITS-1:0]        sample_id,
	input logic                      final_sample,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic signed [31:0]        pixel_x,
	input logic signed [31:0]        pixel_y,
	input logic [ID_BITS-1:0]        vertex_id,
	input logic                      draw_dot,
	input logic                      run_end
);

	logic seen_in_q;   // an item was accepted since reset
	logic seen_out_q;  // a vertex was delivered since reset

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_in_q  <= 1'b0;
			seen_out_q <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				seen_in_q <= 1'b1;
			end
			if (out_valid && out_ready) begin
				seen_out_q <= 1'b1;
			end
		end
	end

	// stalled sample item holds
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(x_sample) && $stable(y_sample)
			&& $stable(sample_id) && $stable(final_sample))
		else $error("sample item changed while stalled");

	// stalled vertex holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(vertex_id) && $stable(draw_dot) && $stable(run_end))
		else $error("vertex changed while stalled");

	// configuration writes are never refused
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

	// no vertex without an item
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		!seen_in_q |-> !out_valid)
		else $error("vertex before any item");

	// first vertex after reset is always a dot
	a_first_dot: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !seen_out_q |-> draw_dot)
		else $error("first vertex not marked as dot");

endmodule

bind min_max_column_decimator_top mmcd_checker #(.ID_BITS(ID_BITS)) u_mmcd_checker (.*);

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the min/max column decimator
// ----------------------------------------------------------------------------
// Samples go in on the in channel and configuration writes on the cfg channel.
// A predictor inside the bench maps each accepted sample to pixel coordinates,
// tracks the open column and its first, lowest, highest and last samples, and
// queues the vertices the block owes. Every vertex that leaves the block is
// compared field by field with the oldest queued vertex. Directed tests cover
// saturation, column order, ties, dot spacing and the mode switch. Random
// series with some noise then run under a long output stall and under several
// register settings, with random gaps on both channels in most phases.
// ----------------------------------------------------------------------------

module testbench;
	import mmcd_pkg::*;

	localparam int ID_W   = DEF_ID_BITS;
	localparam int FRAC_W = DEF_FRAC_BITS;
	localparam int DOT_R  = DEF_DOT_RADIUS_PX;

	// one input item
	typedef struct {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [ID_W-1:0]    id;
		logic               fin;
	} sample_t;

	// one output item
	typedef struct {
		logic signed [31:0] px;
		logic signed [31:0] py;
		logic [ID_W-1:0]    id;
		logic               dot;
		logic               last;
	} vertex_t;

	logic               clk;
	logic               arst_n;
	logic               cfg_valid;
	logic               cfg_ready;
	cfg_reg_t           cfg_index;
	logic [31:0]        cfg_data;
	logic               in_valid;
	logic               in_ready;
	logic signed [31:0] x_sample;
	logic signed [31:0] y_sample;
	logic [ID_W-1:0]    sample_id;
	logic               final_sample;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] pixel_x;
	logic signed [31:0] pixel_y;
	logic [ID_W-1:0]    vertex_id;
	logic               draw_dot;
	logic               run_end;

	// predictor copy of the registers
	logic signed [31:0] x_origin_q;
	logic signed [31:0] y_origin_q;
	logic [31:0]        x_scale_q;
	logic [31:0]        y_scale_q;
	logic [15:0]        left_px_q;
	logic [15:0]        bottom_px_q;
	logic               reduce_q;

	// predictor copy of the column state
	longint             open_col;
	logic               col_open;
	logic [ID_W-1:0]    arrival;
	logic [ID_W-1:0]    kept_pos [4];
	logic [ID_W-1:0]    kept_id [4];
	logic signed [31:0] kept_px [4];
	logic signed [31:0] kept_py [4];
	logic signed [31:0] low_y;
	logic signed [31:0] high_y;
	logic signed [31:0] dot_px;
	logic signed [31:0] dot_py;
	logic               dot_placed;

	vertex_t            expected_vertices [$];
	int                 fail_count;
	int                 hold_off_cycles;
	logic               no_idle;

	min_max_column_decimator_top u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.x_sample     (x_sample),
		.y_sample     (y_sample),
		.sample_id    (sample_id),
		.final_sample (final_sample),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.pixel_x      (pixel_x),
		.pixel_y      (pixel_y),
		.vertex_id    (vertex_id),
		.draw_dot     (draw_dot),
		.run_end      (run_end)
	);

	// 10 ns clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("[min_max_column_decimator_top] ERROR");
		$finish;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	// offset times Q16.16 scale, magnitude clamped, floor rounding is exact here
	function automatic longint scaled_offset(longint diff, logic [31:0] scale);
		logic [63:0] mag;
		logic [63:0] prod;
		mag = (diff < 0) ? -diff : diff;
		prod = mag * 64'(scale);
		if (prod > PROD_CAP)
			prod = PROD_CAP;
		prod = prod << (FRAC_W - 16);
		return (diff < 0) ? -longint'(prod) : longint'(prod);
	endfunction

	// base pixel plus or minus the scaled offset, saturated to 32 bits
	function automatic logic signed [31:0] to_pixel(logic [15:0] base,
			logic signed [31:0] v, logic signed [31:0] origin, logic [31:0] scale,
			logic downward);
		longint off;
		longint sum;
		off = scaled_offset(longint'(v) - longint'(origin), scale);
		sum = (longint'(base) <<< FRAC_W) + (downward ? -off : off);
		if (sum > SAT_MAX)
			return 32'h7fff_ffff;
		if (sum < SAT_MIN)
			return 32'h8000_0000;
		return sum[31:0];
	endfunction

	// queue one vertex, deciding the dot from the distance to the last dot
	function automatic void place_vertex(logic signed [31:0] px, logic signed [31:0] py,
			logic [ID_W-1:0] id, logic forced);
		vertex_t v;
		longint dx;
		longint dy;
		logic [63:0] ax;
		logic [63:0] ay;
		logic [63:0] x2;
		logic [63:0] y2;
		logic [63:0] thr;
		logic dot;
		dot = forced || !dot_placed;
		if (!dot) begin
			dx = longint'(px) - longint'(dot_px);
			dy = longint'(py) - longint'(dot_py);
			ax = (dx < 0) ? -dx : dx;
			ay = (dy < 0) ? -dy : dy;
			thr = 64'(DOT_R * DOT_R) << (2 * FRAC_W);
			x2 = ax * ax;
			y2 = ay * ay;
			if (x2 >= thr || y2 >= thr || x2 + y2 >= thr)
				dot = 1'b1;
		end
		if (dot) begin
			dot_px = px;
			dot_py = py;
			dot_placed = 1'b1;
		end
		v.px = px;
		v.py = py;
		v.id = id;
		v.dot = dot;
		v.last = 1'b0;
		expected_vertices.insert(expected_vertices.size(), v);
	endfunction

	// emit the kept samples of the open column in arrival order, no repeats
	function automatic void flush_open_column();
		logic [ID_W-1:0] prev;
		logic [ID_W-1:0] d_low;
		logic [ID_W-1:0] d_high;
		int a;
		int b;
		if (!col_open)
			return;
		place_vertex(kept_px[0], kept_py[0], kept_id[0], 1'b0);
		prev = kept_pos[0];
		d_low = kept_pos[1] - kept_pos[0];
		d_high = kept_pos[2] - kept_pos[0];
		if (d_low <= d_high) begin
			a = 1;
			b = 2;
		end else begin
			a = 2;
			b = 1;
		end
		if (kept_pos[a] != prev) begin
			place_vertex(kept_px[a], kept_py[a], kept_id[a], 1'b0);
			prev = kept_pos[a];
		end
		if (kept_pos[b] != prev) begin
			place_vertex(kept_px[b], kept_py[b], kept_id[b], 1'b0);
			prev = kept_pos[b];
		end
		if (kept_pos[3] != prev)
			place_vertex(kept_px[3], kept_py[3], kept_id[3], 1'b0);
		col_open = 1'b0;
	endfunction

	function automatic void keep_slot(int slot, logic [ID_W-1:0] pos, logic [ID_W-1:0] id,
			logic signed [31:0] px, logic signed [31:0] py);
		kept_pos[slot] = pos;
		kept_id[slot] = id;
		kept_px[slot] = px;
		kept_py[slot] = py;
	endfunction

	// work out the vertices one accepted sample causes
	function automatic void decimate_sample(sample_t s);
		logic signed [31:0] px;
		logic signed [31:0] py;
		longint col;
		logic [ID_W-1:0] pos;
		int first_new;
		first_new = expected_vertices.size();
		px = to_pixel(left_px_q, s.x, x_origin_q, x_scale_q, 1'b0);
		py = to_pixel(bottom_px_q, s.y, y_origin_q, y_scale_q, 1'b1);
		if (!reduce_q) begin
			// pass mode flushes whatever column is still open
			flush_open_column();
			place_vertex(px, py, s.id, 1'b1);
		end else begin
			col = longint'(px) >>> FRAC_W;
			pos = arrival;
			arrival = arrival + 1'b1;
			if (col_open && col != open_col)
				flush_open_column();
			if (!col_open) begin
				for (int k = 0; k < NUM_SLOTS; k++)
					keep_slot(k, pos, s.id, px, py);
				low_y = s.y;
				high_y = s.y;
				open_col = col;
				col_open = 1'b1;
			end else begin
				// strict compares keep the earliest sample on ties
				if (s.y < low_y) begin
					low_y = s.y;
					keep_slot(1, pos, s.id, px, py);
				end
				if (s.y > high_y) begin
					high_y = s.y;
					keep_slot(2, pos, s.id, px, py);
				end
				keep_slot(3, pos, s.id, px, py);
			end
		end
		if (s.fin) begin
			flush_open_column();
			arrival = '0;
			dot_placed = 1'b0;
		end
		if (expected_vertices.size() > first_new)
			expected_vertices[$].last = 1'b1;
	endfunction

	// ------------------------------------------------------------------------
	// channel drivers
	// ------------------------------------------------------------------------

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic sample_t make_sample(logic signed [31:0] x, logic signed [31:0] y,
			logic [ID_W-1:0] id, logic fin);
		sample_t s;
		s.x = x;
		s.y = y;
		s.id = id;
		s.fin = fin;
		return s;
	endfunction

	// offer one item, valid stays up between back-to-back items
	task automatic send_sample(input sample_t s);
		int gap;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid = 1'b1;
		x_sample = s.x;
		y_sample = s.y;
		sample_id = s.id;
		final_sample = s.fin;
		do @(posedge clk); while (!in_ready);
		decimate_sample(s);
	endtask

	task automatic write_reg(input cfg_reg_t r, input logic [31:0] v);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = r;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		case (r)
			REG_X_ORIGIN:      x_origin_q = v;
			REG_X_SCALE:       x_scale_q = v;
			REG_Y_ORIGIN:      y_origin_q = v;
			REG_Y_SCALE:       y_scale_q = v;
			REG_AREA_LEFT:     left_px_q = v[15:0];
			REG_AREA_BOTTOM:   bottom_px_q = v[15:0];
			REG_REDUCE_ENABLE: reduce_q = v[0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// all owed vertices seen, then let samples that cause none settle
	task automatic wait_idle();
		@(negedge clk);
		in_valid = 1'b0;
		while (expected_vertices.size() != 0)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	// well-formed series around the current origins with some noise mixed in
	task automatic send_series_items(input int count);
		sample_t s;
		int sent;
		int len;
		logic signed [31:0] x_now;
		logic signed [31:0] y_now;
		sent = 0;
		while (sent < count) begin
			len = $urandom_range(2, 30);
			x_now = x_origin_q + $urandom_range(0, 3000);
			y_now = y_origin_q + $urandom_range(0, 200) - 100;
			for (int k = 0; k < len && sent < count; k++) begin
				if ($urandom_range(0, 9) == 0) begin
					// out-of-order noise anywhere in the range
					s.x = $urandom;
					s.y = $urandom;
				end else begin
					x_now = x_now + $urandom_range(0, 2);
					if ($urandom_range(0, 3) == 0)
						y_now = $urandom;
					else
						y_now = y_now + $urandom_range(0, 64) - 32;
					s.x = x_now;
					s.y = y_now;
				end
				s.id = ID_W'($urandom);
				s.fin = (k == len - 1) && ($urandom_range(0, 7) != 0);
				send_sample(s);
				sent++;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// output side
	// ------------------------------------------------------------------------

	// ready with random stalls, or held low while a hold-off is counting down
	initial begin : vertex_sink
		int pause;
		pause = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				out_ready = 1'b0;
				hold_off_cycles--;
			end else if (pause > 0) begin
				out_ready = 1'b0;
				pause--;
			end else begin
				out_ready = 1'b1;
				pause = no_idle ? 0 : pick_gap();
			end
		end
	end

	// compare each accepted vertex with the oldest one owed
	always @(posedge clk) begin : check_vertices
		vertex_t want;
		if (out_valid && out_ready) begin
			if (expected_vertices.size() == 0) begin
				$error("vertex_id %0h arrived with no vertex owed", vertex_id);
				fail_count++;
			end else begin
				want = expected_vertices.pop_front();
				if (pixel_x !== want.px) begin
					$error("pixel_x expected %0d actual %0d", want.px, pixel_x);
					fail_count++;
				end
				if (pixel_y !== want.py) begin
					$error("pixel_y expected %0d actual %0d", want.py, pixel_y);
					fail_count++;
				end
				if (vertex_id !== want.id) begin
					$error("vertex_id expected %0h actual %0h", want.id, vertex_id);
					fail_count++;
				end
				if (draw_dot !== want.dot) begin
					$error("draw_dot expected %0b actual %0b", want.dot, draw_dot);
					fail_count++;
				end
				if (run_end !== want.last) begin
					$error("run_end expected %0b actual %0b", want.last, run_end);
					fail_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------------

	// extreme samples at reset settings, each one its own series
	task automatic test_saturation();
		send_sample(make_sample(32'sh8000_0000, 32'sh7fff_ffff, 20'hfffff, 1'b1));
		send_sample(make_sample(32'sh7fff_ffff, 32'sh8000_0000, 20'h00000, 1'b1));
		send_sample(make_sample(32'sh0000_0000, 32'sh0000_0000, 20'h5a5a5, 1'b1));
	endtask

	// first, lowest, highest and last of a column, ties, order and repeats
	task automatic test_column_order();
		wait_idle();
		// ties on first and on lowest keep the earlier sample
		send_sample(make_sample(5, 10, 20'h00010, 1'b0));
		send_sample(make_sample(5, 10, 20'h00011, 1'b0));
		send_sample(make_sample(5, 3, 20'h00012, 1'b0));
		send_sample(make_sample(5, 20, 20'h00013, 1'b0));
		send_sample(make_sample(5, 3, 20'h00014, 1'b0));
		send_sample(make_sample(5, 7, 20'h00015, 1'b0));
		// highest before lowest, last equals lowest so it is not repeated
		send_sample(make_sample(6, 0, 20'h00020, 1'b0));
		send_sample(make_sample(6, 9, 20'h00021, 1'b0));
		send_sample(make_sample(6, -9, 20'h00022, 1'b1));
		// column change on the final sample: old column then the new one
		send_sample(make_sample(10, 1, 20'h00030, 1'b0));
		send_sample(make_sample(11, 2, 20'h00031, 1'b1));
		// vertices closer than the dot radius
		send_sample(make_sample(20, 0, 20'h00040, 1'b0));
		send_sample(make_sample(20, 1, 20'h00041, 1'b0));
		send_sample(make_sample(21, 1, 20'h00042, 1'b1));
		// x going backward still counts as a column change
		send_sample(make_sample(30, 4, 20'h00050, 1'b0));
		send_sample(make_sample(25, 4, 20'h00051, 1'b1));
	endtask

	// switch to pass mode with a full column open: flush plus the sample
	task automatic test_mode_switch();
		wait_idle();
		send_sample(make_sample(40, 5, 20'h00060, 1'b0));
		send_sample(make_sample(40, 1, 20'h00061, 1'b0));
		send_sample(make_sample(40, 9, 20'h00062, 1'b0));
		send_sample(make_sample(40, 4, 20'h00063, 1'b0));
		wait_idle();
		write_reg(REG_REDUCE_ENABLE, 32'h0000_0000);
		send_sample(make_sample(40, 2, 20'h00064, 1'b0));
		send_sample(make_sample(41, 3, 20'h00065, 1'b1));
		wait_idle();
		// only bit 0 of the data counts
		write_reg(REG_REDUCE_ENABLE, 32'hffff_ffff);
	endtask

	// every register at its extremes, upper data bits set where ignored
	task automatic test_register_extremes();
		wait_idle();
		write_reg(REG_X_ORIGIN, 32'h8000_0000);
		write_reg(REG_X_SCALE, 32'h0000_0000);
		write_reg(REG_Y_ORIGIN, 32'h7fff_ffff);
		write_reg(REG_Y_SCALE, 32'hffff_ffff);
		write_reg(REG_AREA_LEFT, 32'ha5a5_ffff);
		write_reg(REG_AREA_BOTTOM, 32'h5a5a_ffff);
		send_sample(make_sample(0, 0, 20'h00070, 1'b0));
		send_sample(make_sample(32'sh7fff_ffff, 32'sh8000_0000, 20'h00071, 1'b1));
		wait_idle();
		write_reg(REG_X_ORIGIN, 32'h7fff_ffff);
		write_reg(REG_X_SCALE, 32'hffff_ffff);
		write_reg(REG_Y_ORIGIN, 32'h8000_0000);
		write_reg(REG_Y_SCALE, 32'h0000_0000);
		write_reg(REG_AREA_LEFT, 32'h0000_0000);
		write_reg(REG_AREA_BOTTOM, 32'h0000_0000);
		send_sample(make_sample(32'sh8000_0000, 0, 20'h00072, 1'b0));
		send_sample(make_sample(32'sh7fff_ffff, 5, 20'h00073, 1'b1));
	endtask

	// random series under several register settings
	task automatic test_random_series();
		logic [31:0] scale;
		for (int phase = 0; phase < 5; phase++) begin
			wait_idle();
			// one phase without any gaps on either side
			no_idle = (phase == 3);
			write_reg(REG_X_ORIGIN, $urandom);
			scale = ($urandom_range(0, 9) == 0) ? $urandom
				: (32'h0001_0000 >> $urandom_range(0, 5));
			write_reg(REG_X_SCALE, scale);
			write_reg(REG_Y_ORIGIN, $urandom);
			scale = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 32'h0002_0000);
			write_reg(REG_Y_SCALE, scale);
			write_reg(REG_AREA_LEFT, {16'($urandom), 16'($urandom_range(0, 800))});
			write_reg(REG_AREA_BOTTOM, $urandom);
			write_reg(REG_REDUCE_ENABLE, {31'($urandom), phase != 2});
			send_series_items(62);
		end
		wait_idle();
		no_idle = 1'b0;
	endtask

	// output held off long enough that the block backs up into its input
	task automatic test_output_stall();
		wait_idle();
		write_reg(REG_REDUCE_ENABLE, 32'h0000_0000);
		no_idle = 1'b1;
		hold_off_cycles = 300;
		send_series_items(40);
		wait_idle();
		no_idle = 1'b0;
		write_reg(REG_REDUCE_ENABLE, 32'h0000_0001);
	endtask

	// ------------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------------
	initial begin
		// known values on every input from time zero
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_X_ORIGIN;
		cfg_data = '0;
		in_valid = 1'b0;
		x_sample = '0;
		y_sample = '0;
		sample_id = '0;
		final_sample = 1'b0;
		fail_count = 0;
		hold_off_cycles = 0;
		no_idle = 1'b0;

		// predictor starts from the reset state of the block
		x_origin_q = X_ORIGIN_RST;
		y_origin_q = Y_ORIGIN_RST;
		x_scale_q = SCALE_RST;
		y_scale_q = SCALE_RST;
		left_px_q = AREA_RST;
		bottom_px_q = AREA_RST;
		reduce_q = REDUCE_RST;
		open_col = 0;
		col_open = 1'b0;
		arrival = '0;
		dot_px = '0;
		dot_py = '0;
		dot_placed = 1'b0;

		// reset held low at the start, released away from the rising edge
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_saturation();
		test_column_order();
		test_mode_switch();
		test_register_extremes();
		test_output_stall();
		test_random_series();

		// let the pipeline empty and catch any stray vertex
		wait_idle();
		repeat (20) @(posedge clk);
		if (fail_count == 0)
			$display("[min_max_column_decimator_top] OK");
		else
			$display("[min_max_column_decimator_top] ERROR");
		$finish;
	end

endmodule
